// File: hw/rtl/gamepad_serial_poller_defines.svh
// assertion macros for the gamepad serial poller
`ifndef GAMEPAD_SERIAL_POLLER_DEFINES_SVH
`define GAMEPAD_SERIAL_POLLER_DEFINES_SVH

// clocked check, held off during reset
`define GSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check on a presented result
`define GSP_ASSERT_OUT(name, prop, msg) \
  `GSP_ASSERT(name, out_valid |-> (prop), msg)

`endif

// File: hw/rtl/gsp_pkg.sv
`timescale 1ns / 1ps

package gsp_pkg;

  localparam int NUM_BITS    = 16;
  localparam int BIT_IDX_W   = $clog2(NUM_BITS + 1);
  localparam int PRESS_W     = 16;
  localparam int PRESS_IDX_W = $clog2(PRESS_W);
  localparam int TIMER_W     = 16;

  localparam logic [15:0] POLL_INTERVAL_RST = 16'd16000;
  localparam logic [7:0]  LATCH_WIDTH_RST   = 8'd12;
  localparam logic [7:0]  LATCH_GAP_RST     = 8'd6;
  localparam logic [7:0]  CLOCK_HALF_RST    = 8'd6;

  typedef enum logic [1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_LATCH_WIDTH   = 2'd1,
    REG_LATCH_GAP     = 2'd2,
    REG_CLOCK_HALF    = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LATCH    = 3'd1,
    PH_GAP      = 3'd2,
    PH_CLK_LOW  = 3'd3,
    PH_CLK_HIGH = 3'd4
  } phase_t;

  localparam logic signed [1:0] HAT_NEG  = -2'sd1;
  localparam logic signed [1:0] HAT_POS  = 2'sd1;
  localparam logic signed [1:0] HAT_NONE = 2'sd0;

endpackage

// File: hw/rtl/gamepad_serial_poller.sv
`timescale 1ns / 1ps
// gamepad serial poller
// input channel (in_valid/in_ready, data_pin): one request per timebase tick,
//   carrying the sampled controller data line (low means pressed)
// output channel (out_valid/out_ready): one result per accepted tick with the
//   latch and clock pin levels, report_valid and, on report ticks, the
//   pressed bits, button flags and hat axes (zero on all other ticks)
// config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): ready in every
//   cycle that takes no tick; index 0 poll interval, 1 latch width, 2 latch
//   gap, 3 half period of the pin clock; write only while no tick is in flight
// the result for a tick is registered and presented in the cycle after it is accepted
// throughput: one tick per cycle while the receiver takes each result; the tick is
//   decoded against the phase counters in a single pass and lands in one output register
// a stalled receiver holds the output register; in_ready drops only while a
//   result is held and out_ready is low, so no tick is lost or repeated
// reset: phase idle, timers and shift register cleared, registers back to
//   interval 16000, latch width 12, gap 6, half period 6, output empty
module gamepad_serial_poller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              data_pin,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              latch_out,
  output logic              clock_out,
  output logic              report_valid,
  output logic [15:0]       pressed_bits,
  output logic [7:0]        button_flags,
  output logic signed [1:0] hat_x,
  output logic signed [1:0] hat_y,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  logic [15:0] poll_period;
  logic [7:0]  latch_width;
  logic [7:0]  latch_gap;
  logic [7:0]  clock_half;

  gsp_pkg::phase_t                 phase;
  gsp_pkg::phase_t                 phase_next;
  logic [gsp_pkg::TIMER_W-1:0]     phase_timer;
  logic [gsp_pkg::TIMER_W-1:0]     phase_timer_next;
  logic [gsp_pkg::BIT_IDX_W-1:0]   bit_index;
  logic [gsp_pkg::BIT_IDX_W-1:0]   bit_index_next;
  logic [gsp_pkg::PRESS_W-1:0]     shift_bits;
  logic [gsp_pkg::PRESS_W-1:0]     shift_bits_next;

  logic [gsp_pkg::TIMER_W:0]       timer_inc;
  logic [gsp_pkg::BIT_IDX_W-1:0]   bit_inc;
  logic                            rep_now;
  logic                            latch_now;
  logic                            clock_now;
  logic [15:0]                     pressed_now;
  logic [7:0]                      flags_now;
  logic signed [1:0]               hx_now;
  logic signed [1:0]               hy_now;

  logic in_take;
  logic cfg_take;

  assign in_ready  = !out_valid || out_ready;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = !in_take;
  assign cfg_take  = cfg_valid && cfg_ready;

  assign timer_inc = {1'b0, phase_timer} + {{gsp_pkg::TIMER_W{1'b0}}, 1'b1};
  assign bit_inc   = bit_index + {{(gsp_pkg::BIT_IDX_W-1){1'b0}}, 1'b1};

  // next state
  always_comb begin
    phase_next       = phase;
    phase_timer_next = timer_inc[gsp_pkg::TIMER_W-1:0];
    bit_index_next   = bit_index;
    shift_bits_next  = shift_bits;
    rep_now          = 1'b0;
    case (phase)
      gsp_pkg::PH_LATCH: begin
        if (timer_inc >= {9'd0, latch_width}) begin
          phase_next       = gsp_pkg::PH_GAP;
          phase_timer_next = '0;
        end
      end
      gsp_pkg::PH_GAP: begin
        if (timer_inc >= {9'd0, latch_gap}) begin
          if (!data_pin && bit_index < gsp_pkg::BIT_IDX_W'(gsp_pkg::PRESS_W)) begin
            shift_bits_next[bit_index[gsp_pkg::PRESS_IDX_W-1:0]] = 1'b1;
          end
          phase_next       = gsp_pkg::PH_CLK_LOW;
          phase_timer_next = '0;
        end
      end
      gsp_pkg::PH_CLK_LOW: begin
        if (timer_inc >= {9'd0, clock_half}) begin
          phase_next       = gsp_pkg::PH_CLK_HIGH;
          phase_timer_next = '0;
        end
      end
      gsp_pkg::PH_CLK_HIGH: begin
        if (timer_inc >= {9'd0, clock_half}) begin
          phase_timer_next = '0;
          if (bit_inc >= gsp_pkg::BIT_IDX_W'(gsp_pkg::NUM_BITS)) begin
            rep_now        = 1'b1;
            phase_next     = gsp_pkg::PH_IDLE;
            bit_index_next = '0;
          end else begin
            bit_index_next = bit_inc;
            if (!data_pin && bit_inc < gsp_pkg::BIT_IDX_W'(gsp_pkg::PRESS_W)) begin
              shift_bits_next[bit_inc[gsp_pkg::PRESS_IDX_W-1:0]] = 1'b1;
            end
            phase_next = gsp_pkg::PH_CLK_LOW;
          end
        end
      end
      default: begin
        phase_next = gsp_pkg::PH_IDLE;
        if (poll_period == 16'd0) begin
          phase_timer_next = '0;
        end else if (timer_inc >= {1'b0, poll_period}) begin
          phase_next       = gsp_pkg::PH_LATCH;
          phase_timer_next = '0;
          bit_index_next   = '0;
          shift_bits_next  = '0;
        end
      end
    endcase
  end

  // pin levels and report decode
  always_comb begin
    latch_now   = (phase == gsp_pkg::PH_LATCH);
    clock_now   = (phase != gsp_pkg::PH_CLK_LOW);
    pressed_now = '0;
    flags_now   = '0;
    hx_now      = gsp_pkg::HAT_NONE;
    hy_now      = gsp_pkg::HAT_NONE;
    if (rep_now) begin
      pressed_now = shift_bits;
      flags_now   = {shift_bits[11:8], shift_bits[3:0]};
      if (shift_bits[4]) begin
        hy_now = gsp_pkg::HAT_NEG;
      end else if (shift_bits[5]) begin
        hy_now = gsp_pkg::HAT_POS;
      end
      if (shift_bits[6]) begin
        hx_now = gsp_pkg::HAT_NEG;
      end else if (shift_bits[7]) begin
        hx_now = gsp_pkg::HAT_POS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_period   <= gsp_pkg::POLL_INTERVAL_RST;
      latch_width   <= gsp_pkg::LATCH_WIDTH_RST;
      latch_gap     <= gsp_pkg::LATCH_GAP_RST;
      clock_half    <= gsp_pkg::CLOCK_HALF_RST;
      phase         <= gsp_pkg::PH_IDLE;
      phase_timer   <= '0;
      bit_index     <= '0;
      shift_bits    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_take) begin
        phase       <= phase_next;
        phase_timer <= phase_timer_next;
        bit_index   <= bit_index_next;
        shift_bits  <= shift_bits_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_take) begin
        case (gsp_pkg::reg_index_t'(cfg_index))
          gsp_pkg::REG_POLL_INTERVAL: begin
            poll_period <= cfg_data;
            if (cfg_data == 16'd0 && phase == gsp_pkg::PH_IDLE) begin
              phase_timer <= '0;
            end
          end
          gsp_pkg::REG_LATCH_WIDTH: latch_width <= cfg_data[7:0];
          gsp_pkg::REG_LATCH_GAP:   latch_gap   <= cfg_data[7:0];
          gsp_pkg::REG_CLOCK_HALF:  clock_half  <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_take) begin
      latch_out    <= latch_now;
      clock_out    <= clock_now;
      report_valid <= rep_now;
      pressed_bits <= pressed_now;
      button_flags <= flags_now;
      hat_x        <= hx_now;
      hat_y        <= hy_now;
    end
  end

`include "gamepad_serial_poller_defines.svh"

  `GSP_ASSERT_OUT(a_report_pins, !report_valid || (clock_out && !latch_out), "report off clock high")
  `GSP_ASSERT_OUT(a_quiet_fields, report_valid || (pressed_bits == 16'd0 && hat_x == 2'sd0 && hat_y == 2'sd0), "fields set without report")
  `GSP_ASSERT_OUT(a_latch_clock, !(latch_out && !clock_out), "latch high with clock low")
  `GSP_ASSERT(a_result_follows, in_take |=> out_valid, "accepted tick gave no result")

endmodule
